// ===== hdl/bsc_pkg.sv =====
// Shared types and constants for the box support checker.
// Used by every module of the block; depends on nothing.
package bsc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_BOXES     = 1024;
    localparam int TALLY_BITS    = $clog2(MAX_BOXES + 1);
    localparam int EDGE_BITS     = COORD_BITS + 1;
    localparam int CORNER_BITS   = COORD_BITS + 3;
    localparam int PROD_BITS     = 2 * COORD_BITS;
    localparam int AREA_BITS     = 40;
    localparam int Q_BITS        = 16;
    localparam int THR_BITS      = 17;
    localparam int NEED_BITS     = 3;
    localparam int FLAG_BITS     = 4;
    localparam int TPROD_BITS    = THR_BITS + PROD_BITS;
    localparam int CMP_BITS      = AREA_BITS + Q_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    localparam logic MODE_CAND = 1'b0;
    localparam logic MODE_BOX  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CORNER_INSET        = 3'd0,
        REG_TIER_ONE_CORNERS    = 3'd1,
        REG_TIER_ONE_COVERAGE   = 3'd2,
        REG_TIER_TWO_CORNERS    = 3'd3,
        REG_TIER_TWO_COVERAGE   = 3'd4,
        REG_TIER_THREE_CORNERS  = 3'd5,
        REG_TIER_THREE_COVERAGE = 3'd6
    } bsc_reg_e;

    typedef enum logic [1:0] {
        TIER_ONE   = 2'd0,
        TIER_TWO   = 2'd1,
        TIER_THREE = 2'd2
    } bsc_tier_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TIER_A,
        ST_TIER_B,
        ST_TIER_C,
        ST_FINISH
    } bsc_state_e;

    typedef struct packed {
        logic [COORD_BITS-1:0] corner_inset;
        logic [NEED_BITS-1:0]  one_corners;
        logic [THR_BITS-1:0]   one_coverage;
        logic [NEED_BITS-1:0]  two_corners;
        logic [THR_BITS-1:0]   two_coverage;
        logic [NEED_BITS-1:0]  three_corners;
        logic [THR_BITS-1:0]   three_coverage;
    } bsc_cfg_t;

    typedef struct packed {
        logic      accept;
        logic      eval;
        logic      mul_en;
        bsc_tier_e mul_sel;
        logic      cmp_en;
        bsc_tier_e cmp_sel;
        logic      capture;
    } bsc_cmd_t;

    typedef struct packed {
        logic box_valid;
        logic box_mode;
        logic box_last;
        logic res_ready;
    } bsc_stat_t;

endpackage

// ===== hdl/bsc_ifs.sv =====
// Channel interfaces of the box support checker: box input, result output
// and configuration write. Depends on bsc_pkg for widths.
interface bsc_box_if
    import bsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [COORD_BITS-1:0] size_x;
    logic [COORD_BITS-1:0] size_y;
    logic [COORD_BITS-1:0] size_z;
    logic                  last;

    modport source (output valid, mode, pos_x, pos_y, pos_z, size_x, size_y, size_z, last,
                    input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, size_x, size_y, size_z, last,
                    output ready);
endinterface

interface bsc_res_if
    import bsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  supported;
    logic                  on_floor;
    logic                  no_supporter;
    logic [TALLY_BITS-1:0] supporter_count;
    logic [NEED_BITS-1:0]  corners_supported;
    logic [AREA_BITS-1:0]  covered_area;

    modport source (output valid, supported, on_floor, no_supporter, supporter_count,
                    corners_supported, covered_area, input ready);
    modport sink   (input valid, supported, on_floor, no_supporter, supporter_count,
                    corners_supported, covered_area, output ready);
endinterface

interface bsc_cfg_if
    import bsc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/box_support_checker.sv =====
// Box support checker top level: joins configuration bank, controller and
// datapath to the box, result and configuration channels.
// Depends on bsc_pkg, bsc_ifs, bsc_cfg_regs, bsc_ctrl and bsc_datapath.
//
// Send one candidate item (mode 0), then the placed boxes (mode 1), marking
// the final item with last; one result follows each last item. A candidate
// item is only loaded on accept; a placed box is accepted, then evaluated for
// corners and overlap through one 16x16 multiplier. An item marked last then
// runs the tier test, which takes the three coverage thresholds in turn
// through one shared threshold-by-area multiplier, and then waits until the
// output register is free. New items are accepted while a result waits.
// Configuration writes are taken every cycle and belong between lists.
module box_support_checker
    import bsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bsc_box_if.sink   box,
    bsc_res_if.source result,
    bsc_cfg_if.sink   cfg
);

    bsc_cfg_t  cfg_val;
    bsc_cmd_t  cmd;
    bsc_stat_t stat;

    assign cfg.ready = 1'b1;

    bsc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    assign stat.box_valid = box.valid;
    assign stat.box_mode  = box.mode;
    assign stat.box_last  = box.last;
    assign stat.res_ready = result.ready;

    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .cmd       (cmd),
        .box_ready (box.ready),
        .res_valid (result.valid)
    );

    bsc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg_val),
        .mode              (box.mode),
        .pos_x             (box.pos_x),
        .pos_y             (box.pos_y),
        .pos_z             (box.pos_z),
        .size_x            (box.size_x),
        .size_y            (box.size_y),
        .size_z            (box.size_z),
        .supported         (result.supported),
        .on_floor          (result.on_floor),
        .no_supporter      (result.no_supporter),
        .supporter_count   (result.supporter_count),
        .corners_supported (result.corners_supported),
        .covered_area      (result.covered_area)
    );

    // a placed box always gets its evaluation cycle before the next transfer
    a_box_eval_gap: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid && box.ready && (box.mode == MODE_BOX) |=> !box.ready)
        else $error("box ready during evaluation cycle");

    a_floor_supported: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.on_floor |-> result.supported && !result.no_supporter)
        else $error("floor box not reported as supported");

    a_none_unsupported: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.no_supporter |-> !result.supported
                                             && (result.supporter_count == '0))
        else $error("no-supporter result inconsistent");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.corners_supported <= NEED_BITS'(FLAG_BITS))
                      && (result.supporter_count <= TALLY_BITS'(MAX_BOXES)))
        else $error("result count out of range");

endmodule

// ===== hdl/bsc_cfg_regs.sv =====
// Configuration register bank: inset and the three tier thresholds.
// Depends on bsc_pkg.
module bsc_cfg_regs
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output bsc_cfg_t                 cfg
);

    bsc_cfg_t cfg_reg;
    bsc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CORNER_INSET:        cfg_next.corner_inset   = wr_data[COORD_BITS-1:0];
                REG_TIER_ONE_CORNERS:    cfg_next.one_corners    = wr_data[NEED_BITS-1:0];
                REG_TIER_ONE_COVERAGE:   cfg_next.one_coverage   = wr_data[THR_BITS-1:0];
                REG_TIER_TWO_CORNERS:    cfg_next.two_corners    = wr_data[NEED_BITS-1:0];
                REG_TIER_TWO_COVERAGE:   cfg_next.two_coverage   = wr_data[THR_BITS-1:0];
                REG_TIER_THREE_CORNERS:  cfg_next.three_corners  = wr_data[NEED_BITS-1:0];
                REG_TIER_THREE_COVERAGE: cfg_next.three_coverage = wr_data[THR_BITS-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.corner_inset   <= '0;
            cfg_reg.one_corners    <= NEED_BITS'(4);
            cfg_reg.one_coverage   <= THR_BITS'(32768);
            cfg_reg.two_corners    <= NEED_BITS'(3);
            cfg_reg.two_coverage   <= THR_BITS'(49152);
            cfg_reg.three_corners  <= NEED_BITS'(2);
            cfg_reg.three_coverage <= THR_BITS'(58982);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/bsc_ctrl.sv =====
// Controller of the box support checker: sequences accept, evaluate,
// tier test and result hand-off. Depends on bsc_pkg.
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bsc_stat_t stat,
    output bsc_cmd_t  cmd,
    output logic      box_ready,
    output logic      res_valid
);

    bsc_state_e state_reg;
    bsc_state_e state_next;
    logic       last_reg;
    logic       last_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        cmd         = '0;
        cmd.mul_sel = TIER_ONE;
        cmd.cmp_sel = TIER_ONE;
        box_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                box_ready = 1'b1;
                if (stat.box_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = stat.box_last;
                    if (stat.box_mode == MODE_BOX)
                        state_next = ST_EVAL;
                    else if (stat.box_last)
                        state_next = ST_TIER_A;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = last_reg ? ST_TIER_A : ST_IDLE;
            end
            ST_TIER_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = TIER_ONE;
                state_next  = ST_TIER_B;
            end
            ST_TIER_B:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = TIER_ONE;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = TIER_TWO;
                state_next  = ST_TIER_C;
            end
            ST_TIER_C:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = TIER_TWO;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = TIER_THREE;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free or being drained
                cmd.cmp_sel = TIER_THREE;
                if (!out_valid_reg || stat.res_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (stat.res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign res_valid = out_valid_reg;

endmodule

// ===== hdl/bsc_datapath.sv =====
// Datapath of the box support checker: candidate registers, corner and
// overlap evaluation, accumulators, tier multiplier and result registers.
// Depends on bsc_pkg.
module bsc_datapath
    import bsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsc_cmd_t              cmd,
    input  bsc_cfg_t              cfg,
    input  logic                  mode,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [COORD_BITS-1:0] pos_z,
    input  logic [COORD_BITS-1:0] size_x,
    input  logic [COORD_BITS-1:0] size_y,
    input  logic [COORD_BITS-1:0] size_z,
    output logic                  supported,
    output logic                  on_floor,
    output logic                  no_supporter,
    output logic [TALLY_BITS-1:0] supporter_count,
    output logic [NEED_BITS-1:0]  corners_supported,
    output logic [AREA_BITS-1:0]  covered_area
);

    function automatic logic [COORD_BITS-1:0] overlap(
        input logic [EDGE_BITS-1:0] a0,
        input logic [EDGE_BITS-1:0] a1,
        input logic [EDGE_BITS-1:0] b0,
        input logic [EDGE_BITS-1:0] b1
    );
        logic [EDGE_BITS-1:0] hi;
        logic [EDGE_BITS-1:0] lo;
        logic [EDGE_BITS-1:0] diff;
        hi   = (a1 < b1) ? a1 : b1;
        lo   = (a0 > b0) ? a0 : b0;
        diff = hi - lo;
        return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
    endfunction

    // candidate
    logic [COORD_BITS-1:0] cand_x_reg, cand_y_reg, cand_z_reg, cand_dx_reg, cand_dy_reg;
    logic [PROD_BITS-1:0]  base_area_reg;
    // placed box captured at accept
    logic [COORD_BITS-1:0] box_x_reg, box_y_reg, box_z_reg, box_dx_reg, box_dy_reg, box_dz_reg;
    // accumulators
    logic [FLAG_BITS-1:0]  flags_reg, flags_next;
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic [TALLY_BITS-1:0] tally_reg, tally_next;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  pend_reg, pend_next;
    // tier test
    logic [TPROD_BITS-1:0] tprod_reg;
    logic                  thr_zero_reg;
    logic [1:0]            pass_reg, pass_next;
    // result
    logic                  sup_reg, floor_reg, none_reg;
    logic [TALLY_BITS-1:0] count_reg;
    logic [NEED_BITS-1:0]  corners_reg;
    logic [AREA_BITS-1:0]  covered_reg;

    logic                  cand_load;
    logic                  clear_acc;
    logic                  match;
    logic signed [CORNER_BITS-1:0] vx0, vx1, vy0, vy1, bx0, bx1, by0, by1;
    logic                  in_x0, in_x1, in_y0, in_y1;
    logic [FLAG_BITS-1:0]  hit;
    logic [COORD_BITS-1:0] ov_x, ov_y;
    logic [AREA_BITS:0]    area_sum;
    logic [THR_BITS-1:0]   thr_sel;
    logic [NEED_BITS-1:0]  need_sel;
    logic [NEED_BITS-1:0]  corners;
    logic [CMP_BITS-1:0]   cov_lhs;
    logic                  cov_ok;
    logic                  pass_now;
    logic                  floor_now;

    assign cand_load = cmd.accept && (mode == MODE_CAND);
    assign clear_acc = cand_load || cmd.capture;

    // supporter when its top face meets the candidate bottom
    assign match = ({1'b0, box_z_reg} + {1'b0, box_dz_reg}) == {1'b0, cand_z_reg};

    always_comb
    begin
        vx0 = signed'(CORNER_BITS'(cand_x_reg)) + signed'(CORNER_BITS'(cfg.corner_inset));
        vx1 = signed'(CORNER_BITS'(cand_x_reg)) + signed'(CORNER_BITS'(cand_dx_reg))
            - signed'(CORNER_BITS'(cfg.corner_inset));
        vy0 = signed'(CORNER_BITS'(cand_y_reg)) + signed'(CORNER_BITS'(cfg.corner_inset));
        vy1 = signed'(CORNER_BITS'(cand_y_reg)) + signed'(CORNER_BITS'(cand_dy_reg))
            - signed'(CORNER_BITS'(cfg.corner_inset));
        bx0 = signed'(CORNER_BITS'(box_x_reg));
        bx1 = signed'(CORNER_BITS'(box_x_reg)) + signed'(CORNER_BITS'(box_dx_reg));
        by0 = signed'(CORNER_BITS'(box_y_reg));
        by1 = signed'(CORNER_BITS'(box_y_reg)) + signed'(CORNER_BITS'(box_dy_reg));
        in_x0 = (vx0 >= bx0) && (vx0 <= bx1);
        in_x1 = (vx1 >= bx0) && (vx1 <= bx1);
        in_y0 = (vy0 >= by0) && (vy0 <= by1);
        in_y1 = (vy1 >= by0) && (vy1 <= by1);
        hit   = {in_x1 && in_y1, in_x0 && in_y1, in_x1 && in_y0, in_x0 && in_y0};
    end

    assign ov_x = overlap({1'b0, cand_x_reg}, {1'b0, cand_x_reg} + {1'b0, cand_dx_reg},
                          {1'b0, box_x_reg}, {1'b0, box_x_reg} + {1'b0, box_dx_reg});
    assign ov_y = overlap({1'b0, cand_y_reg}, {1'b0, cand_y_reg} + {1'b0, cand_dy_reg},
                          {1'b0, box_y_reg}, {1'b0, box_y_reg} + {1'b0, box_dy_reg});

    assign area_sum = {1'b0, area_reg} + (AREA_BITS + 1)'(prod_reg);

    always_comb
    begin
        flags_next = flags_reg;
        area_next  = area_reg;
        tally_next = tally_reg;
        pend_next  = pend_reg;
        if (clear_acc)
        begin
            flags_next = '0;
            area_next  = '0;
            tally_next = '0;
            pend_next  = 1'b0;
        end
        else
        begin
            // fold in the registered overlap product once evaluation has flagged it pending
            if (pend_reg)
                area_next = (area_sum >= {1'b0, AREA_MAX}) ? AREA_MAX
                                                           : area_sum[AREA_BITS-1:0];
            pend_next = 1'b0;
            if (cmd.eval && match)
            begin
                flags_next = flags_reg | hit;
                pend_next  = 1'b1;
                if (tally_reg < TALLY_BITS'(MAX_BOXES))
                    tally_next = tally_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            TIER_ONE:   thr_sel = cfg.one_coverage;
            TIER_TWO:   thr_sel = cfg.two_coverage;
            TIER_THREE: thr_sel = cfg.three_coverage;
            default:    thr_sel = cfg.three_coverage;
        endcase
        case (cmd.cmp_sel)
            TIER_ONE:   need_sel = cfg.one_corners;
            TIER_TWO:   need_sel = cfg.two_corners;
            TIER_THREE: need_sel = cfg.three_corners;
            default:    need_sel = cfg.three_corners;
        endcase
    end

    assign corners = NEED_BITS'(flags_reg[0]) + NEED_BITS'(flags_reg[1])
                   + NEED_BITS'(flags_reg[2]) + NEED_BITS'(flags_reg[3]);

    // covered * 2^16 >= threshold * base area; empty base passes only a zero threshold
    assign cov_lhs  = {area_reg, {Q_BITS{1'b0}}};
    assign cov_ok   = (base_area_reg == '0) ? thr_zero_reg
                                            : (cov_lhs >= CMP_BITS'(tprod_reg));
    assign pass_now = (corners >= need_sel) && cov_ok;
    assign floor_now = (cand_z_reg == '0);

    always_comb
    begin
        pass_next = pass_reg;
        if (cmd.capture)
            pass_next = '0;
        else if (cmd.cmp_en && (cmd.cmp_sel == TIER_ONE))
            pass_next[0] = pass_now;
        else if (cmd.cmp_en && (cmd.cmp_sel == TIER_TWO))
            pass_next[1] = pass_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_x_reg    <= '0;
            cand_y_reg    <= '0;
            cand_z_reg    <= '0;
            cand_dx_reg   <= '0;
            cand_dy_reg   <= '0;
            base_area_reg <= '0;
            flags_reg     <= '0;
            area_reg      <= '0;
            tally_reg     <= '0;
            pend_reg      <= 1'b0;
            pass_reg      <= '0;
        end
        else
        begin
            if (cand_load)
            begin
                cand_x_reg    <= pos_x;
                cand_y_reg    <= pos_y;
                cand_z_reg    <= pos_z;
                cand_dx_reg   <= size_x;
                cand_dy_reg   <= size_y;
                base_area_reg <= PROD_BITS'(size_x) * PROD_BITS'(size_y);
            end
            flags_reg <= flags_next;
            area_reg  <= area_next;
            tally_reg <= tally_next;
            pend_reg  <= pend_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            box_x_reg  <= pos_x;
            box_y_reg  <= pos_y;
            box_z_reg  <= pos_z;
            box_dx_reg <= size_x;
            box_dy_reg <= size_y;
            box_dz_reg <= size_z;
        end
        if (cmd.eval)
            prod_reg <= PROD_BITS'(ov_x) * PROD_BITS'(ov_y);
        if (cmd.mul_en)
        begin
            tprod_reg    <= TPROD_BITS'(thr_sel) * TPROD_BITS'(base_area_reg);
            thr_zero_reg <= (thr_sel == '0);
        end
        if (cmd.capture)
        begin
            floor_reg   <= floor_now;
            none_reg    <= !floor_now && (tally_reg == '0);
            sup_reg     <= floor_now
                        || ((tally_reg != '0) && (pass_reg[0] || pass_reg[1] || pass_now));
            count_reg   <= tally_reg;
            corners_reg <= corners;
            covered_reg <= area_reg;
        end
    end

    assign supported         = sup_reg;
    assign on_floor          = floor_reg;
    assign no_supporter      = none_reg;
    assign supporter_count   = count_reg;
    assign corners_supported = corners_reg;
    assign covered_area      = covered_reg;

endmodule
